/* hw/rtl/first_fit_block_allocator_assert.svh */
// Assertion macros used by the allocator top level.
// Both expect clk and rst_n in scope.
`ifndef FIRST_FIT_BLOCK_ALLOCATOR_ASSERT_SVH
`define FIRST_FIT_BLOCK_ALLOCATOR_ASSERT_SVH

// Same-cycle implication.
`define FFBA_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define FFBA_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* hw/rtl/ffba_pkg.sv */
package ffba_pkg;

    localparam int MAX_BLOCKS = 16;
    localparam int ADDR_W     = 20;
    localparam int CNT_W      = $clog2(MAX_BLOCKS + 1);
    localparam int HDR_W      = 7;
    localparam int SUM_W      = ADDR_W + 2;
    localparam int CFG_IDX_W  = 2;

    localparam logic [HDR_W-1:0]  HDR_RESET   = HDR_W'(24);
    localparam logic [ADDR_W-1:0] BASE_RESET  = '0;
    localparam logic [ADDR_W-1:0] LIMIT_RESET = ADDR_W'(1048575);

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_HEADER_BYTES = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_HEAP_BASE    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_HEAP_LIMIT   = 2'd2;

    typedef enum logic [0:0] {
        OP_ALLOC = 1'b0,
        OP_FREE  = 1'b1
    } opcode_t;

    typedef enum logic [2:0] {
        ST_OK      = 3'd0,
        ST_ZERO    = 3'd1,
        ST_OOM     = 3'd2,
        ST_NULL    = 3'd3,
        ST_UNKNOWN = 3'd4
    } status_t;

    typedef struct packed {
        opcode_t           opcode;
        logic [ADDR_W-1:0] req_size;
        logic [ADDR_W-1:0] handle;
    } cmd_word_t;

    typedef struct packed {
        status_t           status;
        logic [ADDR_W-1:0] address;
    } rsp_word_t;

    // search token walking down the cell chain
    typedef struct packed {
        logic              valid;
        opcode_t           opcode;
        logic [ADDR_W-1:0] req_size;
        logic [ADDR_W-1:0] handle;
        logic              found;
        logic              last;
        logic [ADDR_W-1:0] start;
    } token_t;

    // append write into one cell
    typedef struct packed {
        logic              en;
        logic [ADDR_W-1:0] start;
        logic [ADDR_W-1:0] size;
    } cell_wr_t;

endpackage

/* hw/rtl/ffba_cell.sv */
module ffba_cell (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic [ffba_pkg::HDR_W-1:0]    hdr,
    input  logic                          live,
    input  logic                          last,
    input  ffba_pkg::cell_wr_t            wr,
    input  ffba_pkg::token_t              tok_in,
    output ffba_pkg::token_t              tok_out
);
    import ffba_pkg::*;

    logic [ADDR_W-1:0] start_reg;
    logic [ADDR_W-1:0] size_reg;
    logic              free_reg;
    token_t            tok_reg;
    token_t            tok_next;

    logic [ADDR_W-1:0] data_addr;
    logic              hit_alloc;
    logic              hit_free;
    logic              hit;

    assign data_addr = start_reg + ADDR_W'(hdr);
    assign hit_alloc = free_reg && (size_reg >= tok_in.req_size);
    assign hit_free  = (data_addr == tok_in.handle);
    assign hit = tok_in.valid && live && !tok_in.found &&
                 ((tok_in.opcode == OP_ALLOC) ? hit_alloc : hit_free);

    always_comb
    begin
        tok_next = tok_in;
        if (hit)
        begin
            tok_next.found = 1'b1;
            tok_next.last  = last;
            tok_next.start = start_reg;
        end
    end

    // entry storage: written on append, free mark set from the opcode on a hit
    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            start_reg <= wr.start;
            size_reg  <= wr.size;
            free_reg  <= 1'b0;
        end
        else if (hit)
        begin
            free_reg <= (tok_in.opcode == OP_FREE);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tok_reg <= '0;
        end
        else
        begin
            tok_reg <= tok_next;
        end
    end

    assign tok_out = tok_reg;

endmodule

/* hw/rtl/first_fit_block_allocator.sv */
// Channel   Direction  Handshake              Word
// cmd       in         cmd_valid/cmd_ready    cmd_word_t  (opcode, req_size, handle)
// rsp       out        rsp_valid/rsp_ready    rsp_word_t  (status, address)
// cfg       in         cfg_we (no wait)       cfg_index, cfg_data
//
// An allocate or free with a nonzero operand is launched into the chain, passes
// through each cell of it in turn, is captured as it leaves the last cell and is
// then finalized. Zero-size allocates and null frees go straight to finalize.
// The search token visits one cell per cycle, so the chain length sets the rate.
// One word is in flight at a time; the response register lets the next word
// enter while a result still waits on rsp_ready.
// Reset clears control, count and break; entry contents stay undefined until
// an append writes them and are never read before that.
`include "first_fit_block_allocator_assert.svh"

module first_fit_block_allocator (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cmd_valid,
    output logic                               cmd_ready,
    input  ffba_pkg::cmd_word_t                cmd,
    output logic                               rsp_valid,
    input  logic                               rsp_ready,
    output ffba_pkg::rsp_word_t                rsp,
    input  logic                               cfg_we,
    input  logic [ffba_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [ffba_pkg::ADDR_W-1:0]        cfg_data
);
    import ffba_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_SCAN = 3'b010,
        S_FIN  = 3'b100
    } state_t;

    state_t             state_reg, state_next;
    token_t             launch_reg, launch_next;
    token_t             fin_reg, fin_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic [ADDR_W-1:0]  brk_reg, brk_next;
    logic [HDR_W-1:0]   hdr_reg, hdr_next;
    logic [ADDR_W-1:0]  base_reg, base_next;
    logic [ADDR_W-1:0]  limit_reg, limit_next;
    logic               rsp_valid_reg, rsp_valid_next;
    rsp_word_t          rsp_reg, rsp_next;

    token_t             tok_chain [0:MAX_BLOCKS];
    token_t             cmd_tok;
    logic               append;
    logic               fin_fire;
    logic [SUM_W-1:0]   end_sum;

    assign cmd_ready = (state_reg == S_IDLE);
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    assign tok_chain[0] = launch_reg;

    // new block would end here: break + header + data
    assign end_sum = SUM_W'(brk_reg) + SUM_W'(hdr_reg) + SUM_W'(fin_reg.req_size);

    always_comb
    begin
        cmd_tok          = '0;
        cmd_tok.valid    = 1'b1;
        cmd_tok.opcode   = cmd.opcode;
        cmd_tok.req_size = cmd.req_size;
        cmd_tok.handle   = cmd.handle;
    end

    // one cell per table entry; the token walks one cell a cycle
    for (genvar i = 0; i < MAX_BLOCKS; i++)
    begin : g_cell
        cell_wr_t cell_wr;
        logic     live;
        logic     last;

        assign live          = (CNT_W'(i) < count_reg);
        assign last          = (CNT_W'(i + 1) == count_reg);
        assign cell_wr.en    = append && (count_reg == CNT_W'(i));
        assign cell_wr.start = brk_reg;
        assign cell_wr.size  = fin_reg.req_size;

        ffba_cell u_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .hdr     (hdr_reg),
            .live    (live),
            .last    (last),
            .wr      (cell_wr),
            .tok_in  (tok_chain[i]),
            .tok_out (tok_chain[i + 1])
        );
    end

    always_comb
    begin
        state_next     = state_reg;
        launch_next    = '0;
        fin_next       = fin_reg;
        count_next     = count_reg;
        brk_next       = brk_reg;
        hdr_next       = hdr_reg;
        base_next      = base_reg;
        limit_next     = limit_reg;
        rsp_valid_next = rsp_valid_reg && !rsp_ready;
        rsp_next       = rsp_reg;
        append         = 1'b0;
        fin_fire       = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (cmd_valid)
                begin
                    fin_next = cmd_tok;
                    // zero size and null handle skip the walk entirely
                    if ((cmd.opcode == OP_ALLOC && cmd.req_size == '0) ||
                        (cmd.opcode == OP_FREE && cmd.handle == '0))
                    begin
                        state_next = S_FIN;
                    end
                    else
                    begin
                        launch_next = cmd_tok;
                        state_next  = S_SCAN;
                    end
                end
            end
            S_SCAN:
            begin
                // capture the token as it leaves the last cell
                if (tok_chain[MAX_BLOCKS].valid)
                begin
                    fin_next   = tok_chain[MAX_BLOCKS];
                    state_next = S_FIN;
                end
            end
            S_FIN:
            begin
                if (!rsp_valid_reg || rsp_ready)
                begin
                    fin_fire         = 1'b1;
                    rsp_valid_next   = 1'b1;
                    rsp_next.address = '0;
                    state_next       = S_IDLE;
                    if (fin_reg.opcode == OP_ALLOC)
                    begin
                        if (fin_reg.req_size == '0)
                        begin
                            rsp_next.status = ST_ZERO;
                        end
                        else if (fin_reg.found)
                        begin
                            rsp_next.status  = ST_OK;
                            rsp_next.address = fin_reg.start + ADDR_W'(hdr_reg);
                        end
                        else if (count_reg == CNT_W'(MAX_BLOCKS) ||
                                 end_sum > SUM_W'(limit_reg))
                        begin
                            rsp_next.status = ST_OOM;
                        end
                        else
                        begin
                            // append at the break and raise it
                            append           = 1'b1;
                            count_next       = count_reg + CNT_W'(1);
                            brk_next         = end_sum[ADDR_W-1:0];
                            rsp_next.status  = ST_OK;
                            rsp_next.address = brk_reg + ADDR_W'(hdr_reg);
                        end
                    end
                    else
                    begin
                        if (fin_reg.handle == '0)
                        begin
                            rsp_next.status = ST_NULL;
                        end
                        else if (fin_reg.found)
                        begin
                            rsp_next.status = ST_OK;
                            // drop the last block and pull the break back
                            if (fin_reg.last)
                            begin
                                count_next = count_reg - CNT_W'(1);
                                brk_next   = fin_reg.start;
                            end
                        end
                        else
                        begin
                            rsp_next.status = ST_UNKNOWN;
                        end
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (cfg_we)
        begin
            case (cfg_index)
                CFG_HEADER_BYTES:
                begin
                    hdr_next = cfg_data[HDR_W-1:0];
                end
                CFG_HEAP_BASE:
                begin
                    base_next = cfg_data;
                    if (count_reg == '0)
                    begin
                        brk_next = cfg_data;
                    end
                end
                CFG_HEAP_LIMIT:
                begin
                    limit_next = cfg_data;
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            launch_reg    <= '0;
            count_reg     <= '0;
            brk_reg       <= BASE_RESET;
            hdr_reg       <= HDR_RESET;
            base_reg      <= BASE_RESET;
            limit_reg     <= LIMIT_RESET;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            launch_reg    <= launch_next;
            count_reg     <= count_next;
            brk_reg       <= brk_next;
            hdr_reg       <= hdr_next;
            base_reg      <= base_next;
            limit_reg     <= limit_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        fin_reg <= fin_next;
        rsp_reg <= rsp_next;
    end

    `FFBA_ASSERT_NOW(a_count_bound, 1'b1, count_reg <= CNT_W'(MAX_BLOCKS),
        "entry count above table size")
    `FFBA_ASSERT_NOW(a_append_room, append, count_reg < CNT_W'(MAX_BLOCKS),
        "append into a full table")
    `FFBA_ASSERT_NOW(a_idle_chain_empty, state_reg == S_IDLE,
        !launch_reg.valid && !tok_chain[MAX_BLOCKS].valid,
        "search token alive while idle")
    `FFBA_ASSERT_NEXT(a_fin_result, fin_fire, rsp_valid_reg,
        "finalized word not presented")

endmodule
